@@ hw/rtl/mesi_pkg.sv @@
// shared types and constants of the mesi snooping cache controller
// no dependencies

package mesi_pkg;

  localparam int NUM_PROCS = 4;
  localparam int PROC_W    = 2;
  localparam int SET_BITS  = 4;
  localparam int WAYS      = 4;
  localparam int WAY_W     = 2;
  localparam int LINE_W    = PROC_W + SET_BITS + WAY_W;
  localparam int NLINES    = 1 << LINE_W;
  localparam int ADDR_W    = 32;
  localparam int STAMP_W   = 32;
  localparam int Q_DEPTH   = 4;
  localparam int QIDX_W    = 2;
  localparam int QCNT_W    = 3;
  localparam int BOB_W     = 4;
  localparam logic [BOB_W-1:0] BOB_RESET = 4'd6;
  localparam logic [1:0] ADDR_BOB = 2'd0;

  typedef enum logic [1:0] {
    ST_I = 2'd0,
    ST_S = 2'd1,
    ST_E = 2'd2,
    ST_M = 2'd3
  } mesi_e;

  typedef enum logic [2:0] {
    OC_HIT     = 3'd0,
    OC_TRUE_SH = 3'd1,
    OC_FALSE_SH = 3'd2,
    OC_UPGRADE = 3'd3,
    OC_COLD    = 3'd4,
    OC_CONFL   = 3'd5,
    OC_DIRTY   = 3'd6,
    OC_REFRESH = 3'd7
  } outcome_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,
    S_LK_EV,
    S_DR_SETUP,
    S_SN_RD,
    S_SN_EV,
    S_OW_RD,
    S_OW_EV,
    S_EV_RD,
    S_EV_EV,
    S_EV_WR
  } state_e;

endpackage

@@ hw/rtl/mesi_snooping_cache_controller.sv @@
// mesi snooping cache controller: four private 4-way caches, lookup, bus queue and drain
// depends on mesi_pkg
//
// usage: an access is taken when start is high and busy is low (proc_id_i, is_write_i,
// mem_address_i, round_last_i). busy stays high while the access is worked on.
// results come one beat at a time on result_valid_o with out_proc_o, outcome_o,
// line_state_o, dirty_delta_o and last_result_o; each beat is shown for exactly
// one cycle and the receiver cannot stall it.
// one sequencer walks the line store one way at a time (read, then evaluate and
// write back) through a memory with registered read and a separate write port. a lookup
// reads the issuer's ways in order until one matches. each drained request runs a setup
// step, a snoop of the three other caches (skipping the issuer), a search of its own
// set, and an lru victim search when no way matches or is free; a round_last access
// drains every queued request and then closes the round. block_offset_bits is written
// through the apb port (address 0); the user must write it only while idle, the block
// itself does not enforce it. reset clears valid bits, request counters and the queue,
// sets the register to 6; no clearing pass runs, the block is ready right after reset.

module mesi_snooping_cache_controller
  import mesi_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [PROC_W-1:0]     proc_id_i,
  input  logic                  is_write_i,
  input  logic [ADDR_W-1:0]     mem_address_i,
  input  logic                  round_last_i,
  output logic                  result_valid_o,
  output logic [PROC_W-1:0]     out_proc_o,
  output logic [2:0]            outcome_o,
  output logic [1:0]            line_state_o,
  output logic signed [1:0]     dirty_delta_o,
  output logic                  last_result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [1:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // config register
  logic [BOB_W-1:0] bob_q;
  assign pready = 1'b1;
  assign prdata = {{(32-BOB_W){1'b0}}, bob_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bob_q <= BOB_RESET;
    end else if (psel && penable && pwrite && paddr[1:0] == ADDR_BOB) begin
      bob_q <= pwdata[BOB_W-1:0];
    end
  end

  // line store
  mesi_e             mem_mesi  [NLINES];
  logic [ADDR_W-1:0] mem_addr  [NLINES];
  logic [STAMP_W-1:0] mem_stamp [NLINES];
  logic              mem_dirty [NLINES];
  logic [NLINES-1:0] valid_q;

  logic [LINE_W-1:0]  rd_idx, wr_idx;
  mesi_e              rd_mesi;
  logic [ADDR_W-1:0]  rd_addr;
  logic [STAMP_W-1:0] rd_stamp;
  logic               rd_dirty;
  logic               we_mesi, we_addr, we_stamp;
  mesi_e              wd_mesi;
  logic               v_set, d_we, d_val;
  logic [ADDR_W-1:0]  cur_addr_q_w;
  logic [STAMP_W-1:0] cur_stamp_w;

  always_ff @(posedge clk_i) begin
    rd_mesi  <= mem_mesi[rd_idx];
    rd_addr  <= mem_addr[rd_idx];
    rd_stamp <= mem_stamp[rd_idx];
    rd_dirty <= mem_dirty[rd_idx];
    if (we_mesi) mem_mesi[wr_idx] <= wd_mesi;
    if (we_addr) mem_addr[wr_idx] <= cur_addr_q_w;
    if (we_stamp) mem_stamp[wr_idx] <= cur_stamp_w;
    if (d_we) mem_dirty[wr_idx] <= d_val;
  end

  // sequencer state
  state_e             state_q, state_d;
  logic [WAY_W-1:0]   way_q, way_d;
  logic [PROC_W-1:0]  pp_q, pp_d;
  logic [QCNT_W-1:0]  j_q, j_d;
  logic [QCNT_W-1:0]  qlen_q, qlen_d;
  logic [PROC_W-1:0]  q_proc_q [Q_DEPTH];
  logic               q_wr_q   [Q_DEPTH];
  logic [ADDR_W-1:0]  q_addr_q [Q_DEPTH];
  logic               enq;
  logic [PROC_W-1:0]  cp_q;
  logic               cw_q, cl_q;
  logic [ADDR_W-1:0]  ca_q;
  logic               load_in, load_req;
  logic               sharing_q, sharing_d;
  logic [STAMP_W-1:0] min_q, min_d;
  logic [WAY_W-1:0]   vic_q, vic_d;
  logic               vdirty_q, vdirty_d;
  logic [STAMP_W-1:0] cnt_q [NUM_PROCS];
  logic               cnt_inc;

  assign cur_addr_q_w = ca_q;
  assign cur_stamp_w  = cnt_q[cp_q];

  logic [SET_BITS-1:0] set_w;
  logic                same_w;
  logic [ADDR_W-1:0]   sh_a, sh_b;
  assign sh_a   = ca_q >> bob_q;
  assign sh_b   = rd_addr >> bob_q;
  assign set_w  = sh_a[SET_BITS-1:0];
  assign same_w = (sh_a == sh_b);

  // first invalid way of the issuer's set
  logic               has_free;
  logic [WAY_W-1:0]   free_way;
  always_comb begin
    logic [LINE_W-1:0] fi;
    has_free = 1'b0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      fi = {cp_q, set_w, WAY_W'(w)};
      if (!valid_q[fi]) begin
        has_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
  end

  // result beat
  logic               em;
  outcome_e           em_oc;
  mesi_e              em_st;
  logic signed [1:0]  em_dd;
  logic               em_last;

  logic [LINE_W-1:0]  cur_idx;
  assign cur_idx = {(state_q == S_SN_RD || state_q == S_SN_EV) ? pp_q : cp_q, set_w, way_q};

  assign busy = (state_q != S_IDLE);

  always_comb begin
    state_d   = state_q;
    way_d     = way_q;
    pp_d      = pp_q;
    j_d       = j_q;
    qlen_d    = qlen_q;
    sharing_d = sharing_q;
    min_d     = min_q;
    vic_d     = vic_q;
    vdirty_d  = vdirty_q;
    enq       = 1'b0;
    load_in   = 1'b0;
    load_req  = 1'b0;
    cnt_inc   = 1'b0;
    rd_idx    = cur_idx;
    wr_idx    = cur_idx;
    we_mesi   = 1'b0;
    we_addr   = 1'b0;
    we_stamp  = 1'b0;
    wd_mesi   = ST_I;
    v_set     = 1'b0;
    d_we      = 1'b0;
    d_val     = 1'b0;
    em        = 1'b0;
    em_oc     = OC_HIT;
    em_st     = ST_I;
    em_dd     = 2'sd0;
    em_last   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          load_in = 1'b1;
          way_d   = '0;
          j_d     = '0;
          if (qlen_q < QCNT_W'(Q_DEPTH)) begin
            state_d = S_LK_RD;
          end else if (round_last_i) begin
            state_d = S_DR_SETUP;
          end
        end
      end

      S_LK_RD: state_d = S_LK_EV;

      S_LK_EV: begin
        if (valid_q[cur_idx] && same_w) begin
          if (rd_mesi == ST_I || (rd_mesi == ST_S && cw_q)) begin
            enq = 1'b1;
            qlen_d = qlen_q + 1'b1;
          end else begin
            em      = 1'b1;
            em_oc   = OC_HIT;
            em_st   = rd_mesi;
            em_last = !(cl_q && qlen_q != '0);
            if (cw_q && rd_mesi == ST_E) begin
              we_mesi = 1'b1;
              wd_mesi = ST_M;
              em_st   = ST_M;
            end
          end
          state_d = cl_q ? S_DR_SETUP : S_IDLE;
        end else if (way_q != WAY_W'(WAYS - 1)) begin
          way_d   = way_q + 1'b1;
          state_d = S_LK_RD;
        end else begin
          enq     = 1'b1;
          qlen_d  = qlen_q + 1'b1;
          state_d = cl_q ? S_DR_SETUP : S_IDLE;
        end
      end

      S_DR_SETUP: begin
        if (j_q == qlen_q) begin
          qlen_d  = '0;
          state_d = S_IDLE;
        end else begin
          load_req  = 1'b1;
          sharing_d = 1'b0;
          pp_d      = '0;
          way_d     = '0;
          state_d   = S_SN_RD;
        end
      end

      S_SN_RD: begin
        if (pp_q == cp_q) begin
          if (pp_q == PROC_W'(NUM_PROCS - 1)) begin
            way_d   = '0;
            state_d = S_OW_RD;
          end else begin
            pp_d = pp_q + 1'b1;
          end
        end else begin
          state_d = S_SN_EV;
        end
      end

      S_SN_EV: begin
        if (valid_q[cur_idx] && rd_mesi != ST_I && same_w) begin
          we_mesi   = 1'b1;
          wd_mesi   = cw_q ? ST_I : ST_S;
          d_we      = 1'b1;
          d_val     = 1'b0;
          sharing_d = 1'b1;
        end
        if (way_q == WAY_W'(WAYS - 1)) begin
          way_d = '0;
          if (pp_q == PROC_W'(NUM_PROCS - 1)) begin
            state_d = S_OW_RD;
          end else begin
            pp_d    = pp_q + 1'b1;
            state_d = S_SN_RD;
          end
        end else begin
          way_d   = way_q + 1'b1;
          state_d = S_SN_RD;
        end
      end

      S_OW_RD: state_d = S_OW_EV;

      S_OW_EV: begin
        if (valid_q[cur_idx] && same_w) begin
          em_oc   = OC_REFRESH;
          wd_mesi = rd_mesi;
          if (rd_mesi == ST_I) begin
            em_oc = (rd_addr == ca_q) ? OC_TRUE_SH : OC_FALSE_SH;
            if (cw_q) begin
              wd_mesi = ST_M;
              em_dd   = 2'sd1;
            end else begin
              wd_mesi = ST_S;
            end
          end else if (cw_q && rd_mesi == ST_S) begin
            em_oc   = OC_UPGRADE;
            d_we    = 1'b1;
            d_val   = 1'b1;
            wd_mesi = ST_M;
            em_dd   = 2'sd1;
          end
          we_mesi  = 1'b1;
          we_addr  = 1'b1;
          we_stamp = 1'b1;
          em       = 1'b1;
          em_st    = wd_mesi;
          em_last  = (j_q == qlen_q - 1'b1);
          cnt_inc  = 1'b1;
          j_d      = j_q + 1'b1;
          state_d  = S_DR_SETUP;
        end else if (way_q != WAY_W'(WAYS - 1)) begin
          way_d   = way_q + 1'b1;
          state_d = S_OW_RD;
        end else if (has_free) begin
          wr_idx   = {cp_q, set_w, free_way};
          we_mesi  = 1'b1;
          we_addr  = 1'b1;
          we_stamp = 1'b1;
          v_set    = 1'b1;
          d_we     = 1'b1;
          d_val    = cw_q;
          wd_mesi  = cw_q ? ST_M : (sharing_q ? ST_S : ST_E);
          em       = 1'b1;
          em_oc    = OC_COLD;
          em_st    = wd_mesi;
          em_dd    = cw_q ? 2'sd1 : 2'sd0;
          em_last  = (j_q == qlen_q - 1'b1);
          cnt_inc  = 1'b1;
          j_d      = j_q + 1'b1;
          state_d  = S_DR_SETUP;
        end else begin
          way_d   = '0;
          state_d = S_EV_RD;
        end
      end

      S_EV_RD: state_d = S_EV_EV;

      S_EV_EV: begin
        // first way with the smallest stamp
        if (way_q == '0 || rd_stamp < min_q) begin
          min_d    = rd_stamp;
          vic_d    = way_q;
          vdirty_d = rd_dirty;
        end
        if (way_q == WAY_W'(WAYS - 1)) begin
          state_d = S_EV_WR;
        end else begin
          way_d   = way_q + 1'b1;
          state_d = S_EV_RD;
        end
      end

      S_EV_WR: begin
        wr_idx   = {cp_q, set_w, vic_q};
        we_mesi  = 1'b1;
        we_addr  = 1'b1;
        we_stamp = 1'b1;
        d_we     = 1'b1;
        d_val    = cw_q;
        wd_mesi  = cw_q ? ST_M : (sharing_q ? ST_S : ST_E);
        em       = 1'b1;
        em_oc    = vdirty_q ? OC_DIRTY : OC_CONFL;
        em_st    = wd_mesi;
        em_dd    = (cw_q ? 2'sd1 : 2'sd0) - (vdirty_q ? 2'sd1 : 2'sd0);
        em_last  = (j_q == qlen_q - 1'b1);
        cnt_inc  = 1'b1;
        j_d      = j_q + 1'b1;
        state_d  = S_DR_SETUP;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      way_q          <= '0;
      pp_q           <= '0;
      j_q            <= '0;
      qlen_q         <= '0;
      sharing_q      <= 1'b0;
      valid_q        <= '0;
      result_valid_o <= 1'b0;
      for (int p = 0; p < NUM_PROCS; p++) cnt_q[p] <= '0;
    end else begin
      state_q        <= state_d;
      way_q          <= way_d;
      pp_q           <= pp_d;
      j_q            <= j_d;
      qlen_q         <= qlen_d;
      sharing_q      <= sharing_d;
      result_valid_o <= em;
      if (v_set) valid_q[wr_idx] <= 1'b1;
      if (cnt_inc) cnt_q[cp_q] <= cnt_q[cp_q] + 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    min_q    <= min_d;
    vic_q    <= vic_d;
    vdirty_q <= vdirty_d;
    if (load_in) begin
      cp_q <= proc_id_i;
      cw_q <= is_write_i;
      ca_q <= mem_address_i;
      cl_q <= round_last_i;
    end else if (load_req) begin
      cp_q <= q_proc_q[j_q[QIDX_W-1:0]];
      cw_q <= q_wr_q[j_q[QIDX_W-1:0]];
      ca_q <= q_addr_q[j_q[QIDX_W-1:0]];
    end
    if (enq) begin
      q_proc_q[qlen_q[QIDX_W-1:0]] <= cp_q;
      q_wr_q[qlen_q[QIDX_W-1:0]]   <= cw_q;
      q_addr_q[qlen_q[QIDX_W-1:0]] <= ca_q;
    end
    if (em) begin
      out_proc_o    <= cp_q;
      outcome_o     <= em_oc;
      line_state_o  <= em_st;
      dirty_delta_o <= em_dd;
      last_result_o <= em_last;
    end
  end

endmodule

@@ test/mesi_snooping_cache_controller_test.sv @@
// testbench of the mesi snooping cache controller: directed and random rounds of accesses
// checked beat by beat against an in-bench coherence predictor; depends on mesi_pkg and the rtl
`timescale 1ns / 100ps

module mesi_snooping_cache_controller_test
  import mesi_pkg::*;
();

  typedef enum logic [1:0] {K_ACCESS, K_SETTLE, K_SET_BOB} job_kind_e;

  typedef struct {
    job_kind_e       kind;
    logic [1:0]      proc;
    logic            wr;
    logic [31:0]     addr;
    logic            last;
    logic [3:0]      bob;
  } job_t;

  typedef struct {
    logic [1:0]        proc;
    outcome_e          oc;
    mesi_e             st;
    logic signed [1:0] dd;
    logic              last;
  } beat_t;

  typedef struct {
    logic [1:0]  proc;
    logic        wr;
    logic [31:0] addr;
  } bus_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] proc_id_i = '0;
  logic is_write_i = 1'b0;
  logic [31:0] mem_address_i = '0;
  logic round_last_i = 1'b0;
  logic result_valid_o;
  logic [1:0] out_proc_o;
  logic [2:0] outcome_o;
  logic [1:0] line_state_o;
  logic signed [1:0] dirty_delta_o;
  logic last_result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mesi_snooping_cache_controller DUT (.*);

  // predictor state
  bit          c_valid[NLINES];
  mesi_e       c_mesi[NLINES];
  bit          c_dirty[NLINES];
  logic [31:0] c_addr[NLINES];
  logic [31:0] c_stamp[NLINES];
  logic [31:0] req_count[NUM_PROCS];
  bus_req_t    bus_q[$];
  int unsigned cur_bob = 6;

  job_t  pending[$];
  beat_t expected_beats[$];
  int    errors = 0;
  int    quiet = 0;
  int    idle_left = 0;
  int    apb_phase = 0;
  bit    taken = 0;
  bit    stim_done = 0;
  int unsigned gen_bob = 6;
  logic [31:0] pool[12];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int set_base(logic [1:0] p, logic [31:0] a);
    logic [31:0] s;
    s = (a >> cur_bob) & 32'd15;
    return (int'(p) * 16 + int'(s)) * WAYS;
  endfunction

  function automatic bit same_block(logic [31:0] a, logic [31:0] b);
    return (a >> cur_bob) == (b >> cur_bob);
  endfunction

  function automatic void post_beat(logic [1:0] p, outcome_e oc, mesi_e st, int dd);
    beat_t b;
    b.proc = p; b.oc = oc; b.st = st; b.dd = dd[1:0]; b.last = 1'b0;
    expected_beats.push_back(b);
  endfunction

  function automatic void drain_request(bus_req_t r);
    int base, v, i, dd;
    bit sharing, done;
    outcome_e oc;
    mesi_e st;
    base = set_base(r.proc, r.addr);
    sharing = 0; done = 0; dd = 0; oc = OC_REFRESH; st = ST_I;
    for (int p = 0; p < NUM_PROCS; p++) begin
      if (p == int'(r.proc)) continue;
      for (int w = 0; w < WAYS; w++) begin
        i = set_base(p[1:0], r.addr) + w;
        if (c_valid[i] && c_mesi[i] != ST_I && same_block(c_addr[i], r.addr)) begin
          c_mesi[i] = r.wr ? ST_I : ST_S;
          c_dirty[i] = 0;
          sharing = 1;
        end
      end
    end
    for (int w = 0; w < WAYS && !done; w++) begin
      i = base + w;
      if (c_valid[i] && same_block(c_addr[i], r.addr)) begin
        if (c_mesi[i] == ST_I) begin
          oc = (c_addr[i] == r.addr) ? OC_TRUE_SH : OC_FALSE_SH;
          if (r.wr) begin
            c_mesi[i] = ST_M; dd = 1;
          end else c_mesi[i] = ST_S;
        end else if (r.wr && c_mesi[i] == ST_S) begin
          oc = OC_UPGRADE; c_dirty[i] = 1; c_mesi[i] = ST_M; dd = 1;
        end
        c_stamp[i] = req_count[r.proc];
        c_addr[i] = r.addr;
        st = c_mesi[i];
        done = 1;
      end
    end
    for (int w = 0; w < WAYS && !done; w++) begin
      i = base + w;
      if (!c_valid[i]) begin
        c_addr[i] = r.addr;
        if (r.wr) begin
          c_dirty[i] = 1; c_mesi[i] = ST_M; dd = 1;
        end else begin
          c_dirty[i] = 0; c_mesi[i] = sharing ? ST_S : ST_E;
        end
        c_stamp[i] = req_count[r.proc];
        c_valid[i] = 1;
        oc = OC_COLD; st = c_mesi[i]; done = 1;
      end
    end
    if (!done) begin
      // lru victim: first way with the smallest stamp
      v = base;
      for (int w = 1; w < WAYS; w++)
        if (c_stamp[base + w] < c_stamp[v]) v = base + w;
      c_addr[v] = r.addr;
      oc = OC_CONFL;
      if (c_dirty[v]) begin
        dd -= 1; oc = OC_DIRTY; c_dirty[v] = 0;
      end
      if (r.wr) begin
        c_dirty[v] = 1; dd += 1; c_mesi[v] = ST_M;
      end else c_mesi[v] = sharing ? ST_S : ST_E;
      c_stamp[v] = req_count[r.proc];
      st = c_mesi[v];
    end
    req_count[r.proc] += 1;
    post_beat(r.proc, oc, st, dd);
  endfunction

  function automatic void predict_access(logic [1:0] p, logic wr, logic [31:0] a, logic last);
    int base, i, n0;
    bit found, enq;
    bus_req_t r;
    n0 = expected_beats.size();
    if (bus_q.size() < Q_DEPTH) begin
      base = set_base(p, a);
      found = 0; enq = 1;
      for (int w = 0; w < WAYS && !found; w++) begin
        i = base + w;
        if (c_valid[i] && same_block(c_addr[i], a)) begin
          found = 1;
          if (!(c_mesi[i] == ST_I || (c_mesi[i] == ST_S && wr))) begin
            enq = 0;
            if (wr && c_mesi[i] == ST_E) c_mesi[i] = ST_M;   // silent upgrade
            post_beat(p, OC_HIT, c_mesi[i], 0);
          end
        end
      end
      if (enq) begin
        r.proc = p; r.wr = wr; r.addr = a;
        bus_q.push_back(r);
      end
    end
    if (last) begin
      foreach (bus_q[j]) drain_request(bus_q[j]);
      bus_q.delete();
    end
    if (expected_beats.size() > n0) expected_beats[expected_beats.size() - 1].last = 1'b1;
  endfunction

  // monitor: accepted beats, results, register writes
  always @(posedge clk_i) begin
    beat_t e;
    taken = start && !busy;
    if (taken) predict_access(proc_id_i, is_write_i, mem_address_i, round_last_i);
    if (psel && penable && pwrite && pready && paddr == ADDR_BOB) cur_bob = pwdata[3:0];
    if (result_valid_o) begin
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: got proc %0d outcome %0d state %0d dd %0d last %0d",
                 $time, out_proc_o, outcome_o, line_state_o, dirty_delta_o, last_result_o);
      end else begin
        e = expected_beats.pop_front();
        if (e.proc !== out_proc_o || e.oc !== outcome_o || e.st !== line_state_o ||
            e.dd !== dirty_delta_o || e.last !== last_result_o) begin
          errors++;
          $display("%0t mismatch: expected proc %0d outcome %0d state %0d dd %0d last %0d",
                   $time, e.proc, e.oc, e.st, e.dd, e.last);
          $display("%0t            got proc %0d outcome %0d state %0d dd %0d last %0d",
                   $time, out_proc_o, outcome_o, line_state_o, dirty_delta_o, last_result_o);
        end
      end
    end
    if (expected_beats.size() == 0 && !busy && !start && !result_valid_o && apb_phase == 0)
      quiet++;
    else quiet = 0;
  end

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
    end else if (apb_phase == 1) begin
      penable <= 1'b1;
      apb_phase = 2;
    end else if (apb_phase == 2) begin
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      apb_phase = 0;
    end else if (start && !taken) begin
    end else if (idle_left > 0) begin
      start <= 1'b0;
      idle_left--;
    end else if (pending.size() == 0) begin
      start <= 1'b0;
    end else begin
      case (pending[0].kind)
        K_ACCESS: begin
          proc_id_i <= pending[0].proc;
          is_write_i <= pending[0].wr;
          mem_address_i <= pending[0].addr;
          round_last_i <= pending[0].last;
          start <= 1'b1;
          void'(pending.pop_front());
          if (pending.size() > 40 && $urandom_range(0, 7) == 0) idle_left = $urandom_range(1, 17);
        end
        K_SETTLE: begin
          start <= 1'b0;
          if (quiet >= 60) void'(pending.pop_front());
        end
        default: begin
          start <= 1'b0;
          if (quiet >= 60) begin
            psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_BOB;
            pwdata <= {28'd0, pending[0].bob};
            apb_phase = 1;
            void'(pending.pop_front());
          end
        end
      endcase
    end
  end

  function automatic void add_access(int p, bit wr, logic [31:0] a, bit last);
    job_t j;
    j.kind = K_ACCESS; j.proc = p[1:0]; j.wr = wr; j.addr = a; j.last = last; j.bob = '0;
    pending.push_back(j);
  endfunction

  function automatic void add_ctrl(job_kind_e k, int unsigned bob);
    job_t j;
    j.kind = k; j.proc = '0; j.wr = 0; j.addr = '0; j.last = 0; j.bob = bob[3:0];
    pending.push_back(j);
    if (k == K_SET_BOB) gen_bob = bob;
  endfunction

  function automatic logic [31:0] pick_addr();
    logic [31:0] a;
    if ($urandom_range(0, 4) == 0) return $urandom;
    a = pool[$urandom_range(0, 11)];
    if ($urandom_range(0, 1) == 0) a = a | ($urandom & ((32'd1 << gen_bob) - 1));
    return a;
  endfunction

  function automatic void add_random_round();
    int n, order[4];
    bit repeats;
    repeats = ($urandom_range(0, 9) == 0);
    n = repeats ? $urandom_range(2, 6) : $urandom_range(1, 4);
    order = '{0, 1, 2, 3};
    order.shuffle();
    for (int k = 0; k < n; k++)
      add_access(repeats ? $urandom_range(0, 3) : order[k], $urandom_range(0, 1),
                 pick_addr(), k == n - 1);
  endfunction

  initial begin
    int bobs[5];
    bobs = '{0, 12, 15, 3, 6};
    foreach (pool[i])
      pool[i] = ($urandom_range(0, 5) << 26) | ($urandom_range(0, 1) << 6) |
                ($urandom_range(0, 1) << 12) | ($urandom_range(0, 1) << 15);
    // directed: cold fills, snoop invalidation, sharing misses, upgrade, refresh
    add_access(0, 0, 32'h0000_1240, 0);
    add_access(1, 1, 32'h0000_1240, 1);
    add_access(0, 0, 32'h0000_1241, 0);
    add_access(1, 0, 32'h0000_1240, 0);
    add_access(2, 1, 32'hFFFF_FFFF, 0);
    add_access(3, 0, 32'h0000_0000, 1);
    add_access(0, 1, 32'h0000_1240, 0);
    add_access(1, 1, 32'h0000_1240, 0);
    add_access(2, 1, 32'hFFFF_FFFF, 1);
    add_access(3, 0, 32'h0000_0000, 0);
    add_access(3, 1, 32'h0000_0000, 1);
    // refresh: the same processor queues the same block twice
    add_access(2, 0, 32'h0004_0080, 0);
    add_access(2, 0, 32'h0004_0080, 1);
    // same set, six tags: four cold fills, then two evictions over dirty lines
    for (int k = 0; k < 5; k++) add_access(3, 1, 32'h1000_0000 * k + 32'h100, 1);
    add_access(3, 0, 32'h5000_0100, 1);
    // queue full: six misses in one round
    for (int k = 0; k < 6; k++) add_access(k % 4, k[0], 32'h00A0_0000 + 32'h40 * k, k == 5);
    add_ctrl(K_SETTLE, 0);
    for (int k = 0; k < 30; k++) add_random_round();
    foreach (bobs[b]) begin
      add_ctrl(K_SET_BOB, bobs[b]);
      for (int k = 0; k < 17; k++) add_random_round();
    end
    stim_done = 1;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    wait (stim_done);
    do @(posedge clk_i);
    while (pending.size() != 0 || start || expected_beats.size() != 0 || quiet < 100);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
